// File: sv/suv_pkg.sv
// suv_pkg: shared widths, stage count and arctangent table for the
// spherical uv generator; no dependencies
package suv_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int DW = 48;   // signed datapath, Q16.28 plus growth room
  localparam int AW = 34;   // signed binary angle, one turn = 2^32
  localparam int GAIN_INV = 39797;

  localparam logic signed [AW-1:0] ANGLE_PI = 34'sd2147483648;
  localparam logic signed [AW-1:0] HALF_PI = 34'sd1073741824;

  // atan(2^-i) as a binary angle
  function automatic logic signed [AW-1:0] atan_of(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/spherical_uv_generator.sv
// spherical_uv_generator: vertex position to spherical texture coordinates
// through two pipelined cordic vectoring chains; depends on suv_pkg
//
// usage:
//   a vertex transfer happens at a rising edge with start high and busy low.
//   busy is always low: the pipeline takes one vertex every cycle.
//   pos_x, pos_y, pos_z are signed Q16.16.
//   the result appears on tex_u and tex_v (unsigned Q0.16) for exactly one
//   cycle with done high, after the entry stage, the first cordic chain, the
//   gain multiply stage, the second chain and the output register. throughput
//   is one vertex per cycle, with one register stage per cordic iteration.
//   results leave in input order. the receiver cannot stall, so nothing
//   ever backs up.
//   synchronous reset clears all valid bits; items in flight are dropped
//   and no done pulse follows until new vertices are transferred.
//   the zero vector gives u = v = 0.5.
module spherical_uv_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               done,
  output logic        [15:0] tex_u,
  output logic        [15:0] tex_v
);
  import suv_pkg::*;

  localparam int N = CORDIC_STAGES;

  // first chain: angle of (x, z)
  logic signed [DW-1:0] c1x [0:N];
  logic signed [DW-1:0] c1y [0:N];
  logic signed [AW-1:0] c1a [0:N];
  logic signed [DW-1:0] c1p [0:N];   // carried y coordinate
  logic                 c1z [0:N];   // zero vector
  logic                 c1q [0:N];   // x and z both zero
  logic                 c1v [0:N];

  // gain correction stage
  logic signed [DW-1:0] mr;
  logic signed [DW-1:0] mp;
  logic signed [AW-1:0] ma;
  logic                 mz;
  logic                 mv;

  // second chain: angle of (r, y)
  logic signed [DW-1:0] c2x [0:N];
  logic signed [DW-1:0] c2y [0:N];
  logic signed [AW-1:0] c2a [0:N];
  logic signed [AW-1:0] c2u [0:N];   // carried first angle
  logic                 c2z [0:N];
  logic                 c2v [0:N];

  logic signed [DW-1:0] sx, sy, sz;
  logic signed [DW-1:0] mag;
  logic        [63:0]   prod;
  logic signed [AW:0]   usum, vsum;
  logic signed [AW:0]   ush, vsh;
  logic        [15:0]   u_next, v_next;

  assign busy = 1'b0;

  // scale into Q16.28
  assign sx = {{(DW-44){pos_x[31]}}, pos_x, 12'b0};
  assign sy = {{(DW-44){pos_y[31]}}, pos_y, 12'b0};
  assign sz = {{(DW-44){pos_z[31]}}, pos_z, 12'b0};

  // entry stage with half-turn pre-rotation for negative x
  always_ff @(posedge clk) begin
    if (rst) begin
      c1v[0] <= 1'b0;
    end else begin
      c1v[0] <= start;
    end
    c1p[0] <= sy;
    c1z[0] <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
    c1q[0] <= (pos_x == '0) && (pos_z == '0);
    if (sx < 0) begin
      c1x[0] <= -sx;
      c1y[0] <= -sz;
      c1a[0] <= (sz >= 0) ? ANGLE_PI : -ANGLE_PI;
    end else begin
      c1x[0] <= sx;
      c1y[0] <= sz;
      c1a[0] <= '0;
    end
  end

  // cordic iterations, one register stage each
  for (genvar i = 0; i < N; i++) begin : g_c1
    always_ff @(posedge clk) begin
      if (rst) begin
        c1v[i+1] <= 1'b0;
      end else begin
        c1v[i+1] <= c1v[i];
      end
      c1p[i+1] <= c1p[i];
      c1z[i+1] <= c1z[i];
      c1q[i+1] <= c1q[i];
      if (c1y[i] >= 0) begin
        c1x[i+1] <= c1x[i] + (c1y[i] >>> i);
        c1y[i+1] <= c1y[i] - (c1x[i] >>> i);
        c1a[i+1] <= c1a[i] + atan_of(i);
      end else begin
        c1x[i+1] <= c1x[i] - (c1y[i] >>> i);
        c1y[i+1] <= c1y[i] + (c1x[i] >>> i);
        c1a[i+1] <= c1a[i] - atan_of(i);
      end
    end
  end

  // gain correction of the magnitude
  assign mag = (c1q[N] || c1x[N] < 0) ? '0 : c1x[N];
  assign prod = 64'(unsigned'(mag)) * 64'(GAIN_INV);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= c1v[N];
    end
    mr <= DW'(signed'(prod[63:16]));
    mp <= c1p[N];
    ma <= c1q[N] ? '0 : c1a[N];
    mz <= c1z[N];
  end

  // second chain entry: r is never negative, so no pre-rotation
  always_comb begin
    c2x[0] = mr;
    c2y[0] = mp;
    c2a[0] = '0;
    c2u[0] = ma;
    c2z[0] = mz;
    c2v[0] = mv;
  end

  for (genvar i = 0; i < N; i++) begin : g_c2
    always_ff @(posedge clk) begin
      if (rst) begin
        c2v[i+1] <= 1'b0;
      end else begin
        c2v[i+1] <= c2v[i];
      end
      c2u[i+1] <= c2u[i];
      c2z[i+1] <= c2z[i];
      if (c2y[i] >= 0) begin
        c2x[i+1] <= c2x[i] + (c2y[i] >>> i);
        c2y[i+1] <= c2y[i] - (c2x[i] >>> i);
        c2a[i+1] <= c2a[i] + atan_of(i);
      end else begin
        c2x[i+1] <= c2x[i] - (c2y[i] >>> i);
        c2y[i+1] <= c2y[i] + (c2x[i] >>> i);
        c2a[i+1] <= c2a[i] - atan_of(i);
      end
    end
  end

  // angle to texture coordinate with rounding and clamping
  always_comb begin
    usum = (AW+1)'(c2u[N]) + (AW+1)'(ANGLE_PI) + (AW+1)'(32768);
    vsum = (AW+1)'(HALF_PI) - (AW+1)'(c2a[N]) + (AW+1)'(16384);
    ush = usum >>> 16;
    vsh = vsum >>> 15;
    if (ush < 0) u_next = '0;
    else if (ush > 65535) u_next = 16'hffff;
    else u_next = ush[15:0];
    if (vsh < 0) v_next = '0;
    else if (vsh > 65535) v_next = 16'hffff;
    else v_next = vsh[15:0];
    if (c2z[N]) begin
      u_next = 16'h8000;
      v_next = 16'h8000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c2v[N];
    end
    tex_u <= u_next;
    tex_v <= v_next;
  end

endmodule

// File: tb/suv_checker.sv
// suv_checker: predicts spherical uv coordinates for each vertex transfer
// and compares them with the results on done; depends on suv_pkg only for the stage count
`timescale 1ns / 1ps

module suv_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               done,
  input  logic        [15:0] tex_u,
  input  logic        [15:0] tex_v,
  output int                 fail_count,
  output int                 pending
);

  localparam int STAGES = suv_pkg::CORDIC_STAGES;
  localparam longint TURN_HALF = 64'sd2147483648;
  localparam longint TURN_QUARTER = 64'sd1073741824;
  localparam longint GAIN_FIX = 39797;

  logic [31:0] uv_queue[$];

  // arctangent step angles, one turn = 2^32
  function automatic longint step_angle(input int i);
    longint tbl[32];
    tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
            81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  // vectoring: angle of (px, py), scaled length in mag
  function automatic longint vector_angle(input longint px_in, input longint py_in,
                                          output longint mag);
    longint px, py, ang, dx, dy;
    int n;
    px = px_in;
    py = py_in;
    ang = 0;
    n = (STAGES > 32) ? 32 : STAGES;
    if (px < 0) begin
      ang = (py >= 0) ? TURN_HALF : -TURN_HALF;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < n; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx;
        py -= dy;
        ang += step_angle(i);
      end else begin
        px -= dx;
        py += dy;
        ang -= step_angle(i);
      end
    end
    mag = px;
    return ang;
  endfunction

  function automatic logic [15:0] clamp_q16(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return v[15:0];
  endfunction

  // expected {u, v} for one vertex
  function automatic logic [31:0] spherical_uv(input logic signed [31:0] vx,
                                               input logic signed [31:0] vy,
                                               input logic signed [31:0] vz);
    longint x, y, z, a1, a2, r, unused;
    x = longint'(vx) * 4096;
    y = longint'(vy) * 4096;
    z = longint'(vz) * 4096;
    a1 = 0;
    r = 0;
    if (x == 0 && y == 0 && z == 0) return {16'd32768, 16'd32768};
    if (x != 0 || z != 0) begin
      a1 = vector_angle(x, z, r);
      if (r < 0) r = 0;
      r = (r * GAIN_FIX) >>> 16;
    end
    a2 = vector_angle(r, y, unused);
    return {clamp_q16((a1 + TURN_HALF + 32768) >>> 16),
            clamp_q16((TURN_QUARTER - a2 + 16384) >>> 15)};
  endfunction

  assign pending = uv_queue.size();

  // record transfers and check results
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (done) begin
        if (uv_queue.size() == 0) begin
          $display("%0t: unexpected result u=%0d v=%0d", $time, tex_u, tex_v);
          fail_count <= fail_count + 1;
        end else begin
          want = uv_queue.pop_front();
          if (want[31:16] !== tex_u || want[15:0] !== tex_v) begin
            $display("%0t: mismatch expected u=%0d v=%0d actual u=%0d v=%0d",
                     $time, want[31:16], want[15:0], tex_u, tex_v);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) uv_queue.push_back(spherical_uv(pos_x, pos_y, pos_z));
    end
  end

endmodule

// File: tb/tb_spherical_uv_generator.sv
// tb_spherical_uv_generator: vertex stimulus and verdict for the spherical
// uv generator; depends on suv_pkg, spherical_uv_generator and suv_checker
`timescale 1ns / 1ps

module tb_spherical_uv_generator;

  localparam int RANDOM_ITEMS = 1950;
  localparam int LATENCY = 2 * suv_pkg::CORDIC_STAGES + 2;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst, start, busy, done;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [15:0] tex_u, tex_v;
  int fail_count, pending;
  int cycle_count = 0;

  spherical_uv_generator uut (.*);
  suv_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one vertex transfer, then a random gap
  task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
    int gap;
    start <= 1'b1;
    pos_x <= vx;
    pos_y <= vy;
    pos_z <= vz;
    do @(posedge clk); while (busy);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      pos_x <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // full range, moderate, small, or sign and low half only, in equal shares
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return ($urandom_range(0, 1) ? 32'h0 : $urandom) & 32'h8000_ffff;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8];
    int waited;
    edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff,
                  32'h0001_0000, 32'hffff_0000, 32'h4000_0000};
    rst = 1'b1;
    start = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axes, negative x with both z signs, extremes
    send_vertex(0, 0, 0);
    send_vertex(0, 32'h0001_0000, 0);
    send_vertex(0, 32'hffff_0000, 0);
    send_vertex(32'hffff_0000, 0, 0);
    send_vertex(32'hffff_0000, 0, 32'hffff_ffff);
    send_vertex(32'hffff_0000, 5, 0);
    send_vertex(32'h0001_0000, 0, 0);
    send_vertex(0, 0, 32'h0001_0000);
    send_vertex(0, 0, 32'hffff_0000);
    for (int i = 0; i < 14; i++)
      send_vertex(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
                  edge_vals[$urandom_range(0, 7)]);

    // random vertices
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord());
    start <= 1'b0;

    // drain
    waited = 0;
    while (pending > 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
